// File: rtl/pfpr_pkg.sv
// ----------------------------------------------------------------------------
// Pump flow PID regulator - shared package
// Widths, flow-band numerators, register indexes and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package pfpr_pkg;

  localparam int PERIOD_W    = 32;
  localparam int SET_W       = 16;
  localparam int GAIN_W      = 16;
  localparam int LIMIT_W     = 16;
  localparam int PWM_W       = 8;
  localparam int ERR_W       = 18;
  localparam int PROD_W      = GAIN_W + ERR_W;
  localparam int FRAC_BITS   = 8;
  localparam int TERM_W      = PROD_W - FRAC_BITS;
  localparam int INT_W       = 32;
  localparam int SUM_W       = 34;
  localparam int SCALE_SHIFT = 5;
  localparam int NUMER_W     = 31;
  localparam int FLOW_W      = 16;
  localparam int DUTY_W      = 9;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 32;

  // The flow is 120e6 * K / (256 * period). 120e6 / 256 is exactly 468750,
  // so each band's numerator is 468750 * K with K in Q8.
  localparam logic [NUMER_W-1:0] NUMER_LOW_BAND = 31'd1080000000; // K = 9.0
  localparam logic [NUMER_W-1:0] NUMER_MID_BAND = 31'd1380000000; // K = 11.5
  localparam logic [NUMER_W-1:0] NUMER_DEFAULT  = 31'd1362187500; // K = 11.35

  localparam logic [SET_W-1:0] LOW_BAND_MIN = 16'd5500;
  localparam logic [SET_W-1:0] LOW_BAND_MAX = 16'd7500;
  localparam logic [SET_W-1:0] MID_BAND_MIN = 16'd1200;
  localparam logic [SET_W-1:0] MID_BAND_MAX = 16'd5600;

  localparam logic [FLOW_W-1:0] FLOW_MAX  = '1;
  localparam logic [DUTY_W-1:0] DUTY_FULL = 9'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P     = 3'd0,
    CFG_GAIN_I     = 3'd1,
    CFG_GAIN_D     = 3'd2,
    CFG_TERM_LIMIT = 3'd3,
    CFG_PWM_UPPER  = 3'd4,
    CFG_PWM_LOWER  = 3'd5
  } pfpr_cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ERR,
    ST_MST,
    ST_MUL,
    ST_ADD,
    ST_SUM,
    ST_OUT
  } pfpr_state_t;

  function automatic logic [NUMER_W-1:0] band_numer(input logic [SET_W-1:0] set);
    logic [NUMER_W-1:0] n;
    if (set > LOW_BAND_MIN && set < LOW_BAND_MAX) begin
      n = NUMER_LOW_BAND;
    end else if (set > MID_BAND_MIN && set < MID_BAND_MAX) begin
      n = NUMER_MID_BAND;
    end else begin
      n = NUMER_DEFAULT;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// File: rtl/pfpr_div.sv
// ----------------------------------------------------------------------------
// Pump flow PID regulator - bit-serial divider
// Restoring division, one quotient bit per clock, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module pfpr_div import pfpr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [NUMER_W-1:0] numer,
  input  logic [PERIOD_W-1:0] denom,
  output logic               done,
  output logic [NUMER_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUMER_W);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [NUMER_W-1:0] num_r, num_nxt;
  logic [NUMER_W-1:0] quot_r, quot_nxt;
  logic [PERIOD_W-1:0] den_r, den_nxt;
  logic [PERIOD_W-1:0] rem_r, rem_nxt;

  logic [PERIOD_W:0]   trial;
  logic [PERIOD_W+1:0] diff;
  logic                fits;

  // A zero divisor always fits, so the quotient comes out all ones.
  assign trial = {rem_r, num_r[NUMER_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, den_r};
  assign fits  = ~diff[PERIOD_W+1];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    quot_nxt = quot_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NUMER_W - 1);
      num_nxt  = numer;
      den_nxt  = denom;
      rem_nxt  = '0;
      quot_nxt = '0;
    end else if (busy_r) begin
      num_nxt  = {num_r[NUMER_W-2:0], 1'b0};
      quot_nxt = {quot_r[NUMER_W-2:0], fits};
      rem_nxt  = fits ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    quot_r <= quot_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

`default_nettype wire

// File: rtl/pfpr_mul.sv
// ----------------------------------------------------------------------------
// Pump flow PID regulator - bit-serial signed multiplier
// Shift-and-add over the multiplier bits, LSB first; the sign bit subtracts.
// ----------------------------------------------------------------------------
`default_nettype none

module pfpr_mul import pfpr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [GAIN_W-1:0] mcand,
  input  logic signed [ERR_W-1:0]  mplier,
  output logic                     done,
  output logic signed [PROD_W-1:0] prod
);

  localparam int CNT_W = $clog2(ERR_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [PROD_W-1:0] mc_r, mc_nxt;
  logic [ERR_W-1:0]  mp_r, mp_nxt;
  logic [PROD_W-1:0] acc_r, acc_nxt;
  logic [PROD_W-1:0] addend;

  assign addend = mp_r[0] ? mc_r : '0;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    mc_nxt   = mc_r;
    mp_nxt   = mp_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(ERR_W - 1);
      mc_nxt   = {{(PROD_W-GAIN_W){mcand[GAIN_W-1]}}, mcand};
      mp_nxt   = mplier;
      acc_nxt  = '0;
    end else if (busy_r) begin
      mc_nxt  = {mc_r[PROD_W-2:0], 1'b0};
      mp_nxt  = {1'b0, mp_r[ERR_W-1:1]};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        // The multiplier's sign bit carries negative weight.
        acc_nxt  = acc_r - addend;
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        acc_nxt = acc_r + addend;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mc_r  <= mc_nxt;
    mp_r  <= mp_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign prod = $signed(acc_r);

endmodule

`default_nettype wire

// File: rtl/pump_flow_pid_regulator_unit.sv
// An accepted beat passes through the divider, the error step, the multiplier
// start, the three multipliers, the add steps and the output step; the next
// beat is taken only once the block is back in idle. A result waiting in the
// output register holds the block only at its final step.
// Reset (rst_n low, synchronous) clears the sequencer, the output valid bit, the
// integral, previous error and running PWM, and loads the register defaults.
// ----------------------------------------------------------------------------
// Pump flow PID regulator - top level
// Flow estimate by serial division, PID terms by serial multiplication, and
// the clamped, inverted PWM duty ratio on a streaming output.
// ----------------------------------------------------------------------------
`default_nettype none

module pump_flow_pid_regulator_unit import pfpr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata: measured_period [31:0], set_point [47:32]
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // out_tdata: duty_ratio [8:0], flow_estimate [24:9], zero [31:25]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  // --------------------------------------------------------------------------
  // Configuration registers. Writes to indexes past the list are dropped.
  // --------------------------------------------------------------------------
  logic signed [GAIN_W-1:0] gain_p_r, gain_p_nxt;
  logic signed [GAIN_W-1:0] gain_i_r, gain_i_nxt;
  logic signed [GAIN_W-1:0] gain_d_r, gain_d_nxt;
  logic [LIMIT_W-1:0]       term_limit_r, term_limit_nxt;
  logic [PWM_W-1:0]         pwm_upper_r, pwm_upper_nxt;
  logic [PWM_W-1:0]         pwm_lower_r, pwm_lower_nxt;

  always_comb begin
    gain_p_nxt     = gain_p_r;
    gain_i_nxt     = gain_i_r;
    gain_d_nxt     = gain_d_r;
    term_limit_nxt = term_limit_r;
    pwm_upper_nxt  = pwm_upper_r;
    pwm_lower_nxt  = pwm_lower_r;
    if (cfg_we) begin
      case (pfpr_cfg_reg_t'(cfg_index))
        CFG_GAIN_P:     gain_p_nxt     = $signed(cfg_wdata[GAIN_W-1:0]);
        CFG_GAIN_I:     gain_i_nxt     = $signed(cfg_wdata[GAIN_W-1:0]);
        CFG_GAIN_D:     gain_d_nxt     = $signed(cfg_wdata[GAIN_W-1:0]);
        CFG_TERM_LIMIT: term_limit_nxt = cfg_wdata[LIMIT_W-1:0];
        CFG_PWM_UPPER:  pwm_upper_nxt  = cfg_wdata[PWM_W-1:0];
        CFG_PWM_LOWER:  pwm_lower_nxt  = cfg_wdata[PWM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer state, controller state and the working registers of one beat.
  // --------------------------------------------------------------------------
  pfpr_state_t state_r, state_nxt;

  logic signed [INT_W-1:0]  integral_r, integral_nxt;
  logic signed [ERR_W-1:0]  prev_err_r, prev_err_nxt;
  logic [DUTY_W-1:0]        pwm_r, pwm_nxt;

  logic [SET_W-1:0]         set_r, set_nxt;
  logic [FLOW_W-1:0]        flow_r, flow_nxt;
  logic signed [ERR_W-1:0]  err_r, err_nxt;
  logic signed [ERR_W-1:0]  dclip_r, dclip_nxt;
  logic signed [TERM_W-1:0] p_r, p_nxt;
  logic signed [INT_W-1:0]  i_r, i_nxt;
  logic signed [TERM_W-1:0] d_r, d_nxt;
  logic signed [SUM_W-1:0]  s1_r, s1_nxt;
  logic signed [SUM_W-1:0]  s2_r, s2_nxt;
  logic signed [SUM_W-1:0]  total_r, total_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [DUTY_W-1:0]        out_duty_r, out_duty_nxt;
  logic [FLOW_W-1:0]        out_flow_r, out_flow_nxt;

  // --------------------------------------------------------------------------
  // Serial units. The divider starts on the accepting edge itself, with the
  // band numerator picked straight from the incoming set point. The three
  // multipliers run side by side and finish together.
  // --------------------------------------------------------------------------
  logic                     in_accept;
  logic                     div_done;
  logic [NUMER_W-1:0]       div_quot;
  logic                     mul_start;
  logic                     mul_p_done, mul_i_done, mul_d_done;
  logic signed [PROD_W-1:0] prod_p, prod_i, prod_d;

  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign mul_start = (state_r == ST_MST);

  pfpr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_accept),
    .numer (band_numer(in_tdata[PERIOD_W +: SET_W])),
    .denom (in_tdata[PERIOD_W-1:0]),
    .done  (div_done),
    .quot  (div_quot)
  );

  pfpr_mul u_mul_p (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (gain_p_r),
    .mplier (err_r),
    .done   (mul_p_done),
    .prod   (prod_p)
  );

  pfpr_mul u_mul_i (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (gain_i_r),
    .mplier (err_r),
    .done   (mul_i_done),
    .prod   (prod_i)
  );

  pfpr_mul u_mul_d (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (gain_d_r),
    .mplier (dclip_r),
    .done   (mul_d_done),
    .prod   (prod_d)
  );

  // --------------------------------------------------------------------------
  // Datapath pieces. The products are Q8, so dropping the low eight bits of
  // the two's complement word gives the floor of the scaled term.
  // --------------------------------------------------------------------------
  logic signed [ERR_W-1:0]  err_c, diff_c, lim_e;
  logic signed [TERM_W-1:0] p_q, i_q, d_q, lim_t;
  logic signed [INT_W:0]    i_sum, i_hi, lim_x, int_min_x;
  logic signed [SUM_W-1:0]  scaled, up_x, lo_x, clamp_a, clamp_b;
  logic [PWM_W-1:0]         pwm_scaled;
  logic [DUTY_W-1:0]        duty_c;

  assign lim_e     = $signed({{(ERR_W-LIMIT_W){1'b0}}, term_limit_r});
  assign lim_t     = $signed({{(TERM_W-LIMIT_W){1'b0}}, term_limit_r});
  assign lim_x     = $signed({{(INT_W+1-LIMIT_W){1'b0}}, term_limit_r});
  assign int_min_x = $signed({2'b11, {(INT_W-1){1'b0}}});

  // Error and the clipped error difference; set point and flow are both
  // below 2^16, so both differences fit the error width exactly.
  assign err_c  = $signed({{(ERR_W-SET_W){1'b0}}, set_r})
                - $signed({{(ERR_W-FLOW_W){1'b0}}, flow_r});
  assign diff_c = err_c - prev_err_r;

  assign p_q = $signed(prod_p[PROD_W-1:FRAC_BITS]);
  assign i_q = $signed(prod_i[PROD_W-1:FRAC_BITS]);
  assign d_q = $signed(prod_d[PROD_W-1:FRAC_BITS]);

  // The integral is clamped above by the term limit and saturates below.
  assign i_sum = $signed({integral_r[INT_W-1], integral_r})
               + $signed({{(INT_W+1-TERM_W){i_q[TERM_W-1]}}, i_q});
  assign i_hi  = (i_sum > lim_x) ? lim_x : i_sum;

  // Scale down by 32 with floor, then apply the upper bound and after it the
  // lower one, so crossed bounds settle on the lower bound.
  assign scaled     = total_r >>> SCALE_SHIFT;
  assign up_x       = $signed({{(SUM_W-PWM_W){1'b0}}, pwm_upper_r});
  assign lo_x       = $signed({{(SUM_W-PWM_W){1'b0}}, pwm_lower_r});
  assign clamp_a    = (scaled > up_x) ? up_x : scaled;
  assign clamp_b    = (clamp_a < lo_x) ? lo_x : clamp_a;
  assign pwm_scaled = clamp_b[PWM_W-1:0];
  assign duty_c     = DUTY_FULL - {1'b0, pwm_scaled};

  // --------------------------------------------------------------------------
  // Next state and datapath updates.
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    integral_nxt  = integral_r;
    prev_err_nxt  = prev_err_r;
    pwm_nxt       = pwm_r;
    set_nxt       = set_r;
    flow_nxt      = flow_r;
    err_nxt       = err_r;
    dclip_nxt     = dclip_r;
    p_nxt         = p_r;
    i_nxt         = i_r;
    d_nxt         = d_r;
    s1_nxt        = s1_r;
    s2_nxt        = s2_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_duty_nxt  = out_duty_r;
    out_flow_nxt  = out_flow_r;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          set_nxt   = in_tdata[PERIOD_W +: SET_W];
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          // A zero period divides to all ones and so saturates here as well.
          flow_nxt  = (div_quot > NUMER_W'(FLOW_MAX)) ? FLOW_MAX : div_quot[FLOW_W-1:0];
          state_nxt = ST_ERR;
        end
      end
      ST_ERR: begin
        err_nxt   = err_c;
        dclip_nxt = (diff_c > lim_e) ? lim_e : diff_c;
        state_nxt = ST_MST;
      end
      ST_MST: begin
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (mul_p_done && mul_i_done && mul_d_done) begin
          p_nxt        = (p_q > lim_t) ? lim_t : p_q;
          i_nxt        = (i_hi < int_min_x) ? int_min_x[INT_W-1:0] : i_hi[INT_W-1:0];
          d_nxt        = d_q;
          integral_nxt = (i_hi < int_min_x) ? int_min_x[INT_W-1:0] : i_hi[INT_W-1:0];
          prev_err_nxt = err_r;
          state_nxt    = ST_ADD;
        end
      end
      ST_ADD: begin
        s1_nxt    = $signed({{(SUM_W-DUTY_W){1'b0}}, pwm_r})
                  + $signed({{(SUM_W-TERM_W){p_r[TERM_W-1]}}, p_r});
        s2_nxt    = $signed({{(SUM_W-INT_W){i_r[INT_W-1]}}, i_r})
                  + $signed({{(SUM_W-TERM_W){d_r[TERM_W-1]}}, d_r});
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        total_nxt = s1_r + s2_r;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // Load the output register once it is free or being emptied.
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_duty_nxt  = duty_c;
          out_flow_nxt  = flow_r;
          pwm_nxt       = duty_c;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      integral_r   <= '0;
      prev_err_r   <= '0;
      pwm_r        <= '0;
      gain_p_r     <= '0;
      gain_i_r     <= '0;
      gain_d_r     <= '0;
      term_limit_r <= '1;
      pwm_upper_r  <= '1;
      pwm_lower_r  <= '0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      integral_r   <= integral_nxt;
      prev_err_r   <= prev_err_nxt;
      pwm_r        <= pwm_nxt;
      gain_p_r     <= gain_p_nxt;
      gain_i_r     <= gain_i_nxt;
      gain_d_r     <= gain_d_nxt;
      term_limit_r <= term_limit_nxt;
      pwm_upper_r  <= pwm_upper_nxt;
      pwm_lower_r  <= pwm_lower_nxt;
    end
  end

  always_ff @(posedge clk) begin
    set_r      <= set_nxt;
    flow_r     <= flow_nxt;
    err_r      <= err_nxt;
    dclip_r    <= dclip_nxt;
    p_r        <= p_nxt;
    i_r        <= i_nxt;
    d_r        <= d_nxt;
    s1_r       <= s1_nxt;
    s2_r       <= s2_nxt;
    total_r    <= total_nxt;
    out_duty_r <= out_duty_nxt;
    out_flow_r <= out_flow_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-DUTY_W-FLOW_W){1'b0}}, out_flow_r, out_duty_r};

endmodule

`default_nettype wire

// File: rtl/pfpr_checker.sv
// ----------------------------------------------------------------------------
// Pump flow PID regulator - port checker
// Watches the streaming ports of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module pfpr_checker import pfpr_pkg::*; (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata
);

  // One beat at a time: the block is busy right after taking one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a beat is still being worked on");

  // A new result appears only as the block returns to idle.
  a_result_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> in_tready)
    else $error("result raised while the block is still busy");

  // The duty ratio stays within one to 256.
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[DUTY_W-1:0] != '0) && (out_tdata[DUTY_W-1:0] <= DUTY_FULL))
    else $error("duty ratio out of range");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output beat changed");

endmodule

bind pump_flow_pid_regulator_unit pfpr_checker u_pfpr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// File: test/pump_flow_pid_regulator_checker.sv
// ----------------------------------------------------------------------------
// Pump flow PID regulator - stream checker
// Watches the register port and both streams, keeps its own copy of the
// regulator state and compares every result beat with the oldest prediction.
// ----------------------------------------------------------------------------

module pump_flow_pid_regulator_checker import pfpr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  // in_tdata: measured_period [31:0], set_point [47:32]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  // out_tdata: duty_ratio [8:0], flow_estimate [24:9], zero [31:25]
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output int                     pending_results,
  output int                     mismatch_count
);

  typedef struct packed {
    logic [DUTY_W-1:0] duty_ratio;
    logic [FLOW_W-1:0] flow_estimate;
  } duty_result_t;

  // Band factors in Q8: 9.0, 11.5 and 11.35 rounded to nearest.
  localparam longint unsigned FLOW_SCALE   = 120000000;
  localparam longint unsigned K_Q8_LOW     = 2304;
  localparam longint unsigned K_Q8_MID     = 2944;
  localparam longint unsigned K_Q8_DEFAULT = 2906;
  localparam longint          FLOW_CEIL    = 65535;
  localparam longint          DUTY_SPAN    = 256;
  localparam longint          INT32_FLOOR  = -64'sd2147483648;

  longint gain_p_q, gain_i_q, gain_d_q, term_cap, scaled_hi, scaled_lo;
  longint integral_acc, last_error, pwm_running;
  duty_result_t duty_expected_q[$];
  int fail_tally = 0;

  // One regulator update; advances the shadow state as the block would.
  function automatic duty_result_t regulate(input logic [PERIOD_W-1:0] period,
                                            input logic [SET_W-1:0]    set_pt);
    longint unsigned k_q8, quo;
    longint set_l, flow, err, p_term, i_term, d_term, diff, total;
    duty_result_t r;
    set_l = longint'(set_pt);
    if (set_pt > LOW_BAND_MIN && set_pt < LOW_BAND_MAX) begin
      k_q8 = K_Q8_LOW;
    end else if (set_pt > MID_BAND_MIN && set_pt < MID_BAND_MAX) begin
      k_q8 = K_Q8_MID;
    end else begin
      k_q8 = K_Q8_DEFAULT;
    end
    if (period == '0) begin
      flow = FLOW_CEIL;
    end else begin
      quo  = (FLOW_SCALE * k_q8) / ({32'd0, period} * 64'd256);
      flow = (quo > 64'd65535) ? FLOW_CEIL : longint'(quo);
    end
    err = set_l - flow;

    p_term = (gain_p_q * err) >>> FRAC_BITS;
    if (p_term > term_cap) p_term = term_cap;

    i_term = integral_acc + ((gain_i_q * err) >>> FRAC_BITS);
    if (i_term > term_cap) i_term = term_cap;
    if (i_term < INT32_FLOOR) i_term = INT32_FLOOR;
    integral_acc = i_term;

    diff = err - last_error;
    if (diff > term_cap) diff = term_cap;
    d_term = (gain_d_q * diff) >>> FRAC_BITS;
    last_error = err;

    total = (pwm_running + p_term + i_term + d_term) >>> SCALE_SHIFT;
    if (total > scaled_hi) total = scaled_hi;
    if (total < scaled_lo) total = scaled_lo;
    total = DUTY_SPAN - total;
    pwm_running = total;

    r.duty_ratio    = total[DUTY_W-1:0];
    r.flow_estimate = flow[FLOW_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    duty_result_t want;
    if (!rst_n) begin
      gain_p_q     = 0;
      gain_i_q     = 0;
      gain_d_q     = 0;
      term_cap     = 65535;
      scaled_hi    = 255;
      scaled_lo    = 0;
      integral_acc = 0;
      last_error   = 0;
      pwm_running  = 0;
      duty_expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (pfpr_cfg_reg_t'(cfg_index))
          CFG_GAIN_P:     gain_p_q  = longint'($signed(cfg_wdata));
          CFG_GAIN_I:     gain_i_q  = longint'($signed(cfg_wdata));
          CFG_GAIN_D:     gain_d_q  = longint'($signed(cfg_wdata));
          CFG_TERM_LIMIT: term_cap  = longint'(cfg_wdata);
          CFG_PWM_UPPER:  scaled_hi = longint'(cfg_wdata[PWM_W-1:0]);
          CFG_PWM_LOWER:  scaled_lo = longint'(cfg_wdata[PWM_W-1:0]);
          default: ;
        endcase
      end

      if (out_tvalid && out_tready) begin
        if (duty_expected_q.size() == 0) begin
          $error("result beat arrived with no prediction waiting: %h", out_tdata);
          fail_tally++;
        end else begin
          want = duty_expected_q.pop_front();
          if (out_tdata[DUTY_W-1:0] !== want.duty_ratio) begin
            $error("duty_ratio: expected %0d, actual %0d",
                   want.duty_ratio, out_tdata[DUTY_W-1:0]);
            fail_tally++;
          end
          if (out_tdata[DUTY_W +: FLOW_W] !== want.flow_estimate) begin
            $error("flow_estimate: expected %0d, actual %0d",
                   want.flow_estimate, out_tdata[DUTY_W +: FLOW_W]);
            fail_tally++;
          end
          if (out_tdata[OUT_TDATA_W-1:DUTY_W+FLOW_W] !== '0) begin
            $error("padding: expected 0, actual %0d",
                   out_tdata[OUT_TDATA_W-1:DUTY_W+FLOW_W]);
            fail_tally++;
          end
        end
      end

      if (in_tvalid && in_tready) begin
        duty_expected_q.push_back(regulate(in_tdata[PERIOD_W-1:0],
                                           in_tdata[PERIOD_W +: SET_W]));
      end
    end
    pending_results <= duty_expected_q.size();
    mismatch_count  <= fail_tally;
  end

endmodule

// File: test/pump_flow_pid_regulator_unit_tb.sv
// ----------------------------------------------------------------------------
// Pump flow PID regulator - testbench top
// Drives sensor samples and register writes into the regulator, randomises
// back-pressure on both streams and reports the checker's verdict.
// ----------------------------------------------------------------------------

module pump_flow_pid_regulator_unit_tb import pfpr_pkg::*; ();

  // Register indexes past the last real register; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  // Set points on either side of every band edge, plus the field extremes.
  localparam logic [11:0][SET_W-1:0] SET_MARKS = {
    16'd0,    16'd1200, 16'd1201, 16'd5499, 16'd5500, 16'd5501,
    16'd5599, 16'd5600, 16'd5601, 16'd7499, 16'd7500, 16'hFFFF
  };

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tready = 1'b0;
  logic                   cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;
  logic                   in_tready;
  logic                   out_tvalid;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Percentage of decisions on which each side holds off; changed per phase.
  int send_idle_pct = 30;
  int recv_idle_pct = 65;
  int pending_results;
  int mismatch_count;

  pump_flow_pid_regulator_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  pump_flow_pid_regulator_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .pending_results (pending_results),
    .mismatch_count  (mismatch_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block stops handshaking altogether.
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  // The receiver holds ready high or low for stretches of random length, so a
  // finished result sometimes waits and sometimes leaves at once. With the
  // idle percentage at zero the stretches are all ready.
  initial begin
    int  hold;
    bit  stall;
    forever begin
      hold  = $urandom_range(20, 1);
      stall = ($urandom_range(99) < recv_idle_pct);
      repeat (hold) begin
        out_tready <= !stall;
        @(posedge clk);
      end
    end
  end

  // Raises the write enable and keeps it high; the caller lowers it once the
  // whole batch of writes has gone, so it never drops and rises in one step.
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx,
                         input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic load_regs(input logic [CFG_DATA_W-1:0] gp, gi, gd, cap,
                           input logic [PWM_W-1:0]      hi_b, lo_b);
    put_reg(CFG_GAIN_P, gp);
    put_reg(CFG_GAIN_I, gi);
    put_reg(CFG_GAIN_D, gd);
    put_reg(CFG_TERM_LIMIT, cap);
    put_reg(CFG_PWM_UPPER, {8'd0, hi_b});
    put_reg(CFG_PWM_LOWER, {8'd0, lo_b});
    cfg_we <= 1'b0;
  endtask

  // Gains are mostly small so that the duty ratio settles inside its bounds,
  // with the signed extremes and full-range values mixed in.
  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    logic [CFG_DATA_W-1:0] g;
    case ($urandom_range(7))
      0:       g = 16'h8000;
      1:       g = 16'h7FFF;
      2, 3:    g = 16'($urandom);
      default: g = 16'(int'($urandom_range(160)) - 80);
    endcase
    return g;
  endfunction

  task automatic shuffle_regs();
    logic [CFG_DATA_W-1:0] cap;
    logic [PWM_W-1:0]      hi_b, lo_b;
    case ($urandom_range(3))
      0:       cap = '0;
      1:       cap = '1;
      default: cap = 16'($urandom);
    endcase
    // Picking an extreme for both bounds now and then crosses them.
    case ($urandom_range(4))
      0:       hi_b = 8'd0;
      1:       hi_b = 8'd255;
      default: hi_b = 8'($urandom_range(255, 150));
    endcase
    case ($urandom_range(4))
      0:       lo_b = 8'd0;
      1:       lo_b = 8'd255;
      default: lo_b = 8'($urandom_range(40));
    endcase
    if ($urandom_range(3) == 0) begin
      put_reg($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, 16'($urandom));
    end
    load_regs(pick_gain(), pick_gain(), pick_gain(), cap, hi_b, lo_b);
  endtask

  // Offers one sample beat, sometimes after a gap long enough to land anywhere
  // in the block's update, and returns just after the accepting edge with valid
  // still high.
  task automatic push_sample(input logic [PERIOD_W-1:0] period,
                             input logic [SET_W-1:0]    set_pt);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(120, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {set_pt, period};
    do @(posedge clk); while (!in_tready);
  endtask

  // Periods cluster where the flow estimate lands inside its range, with zero,
  // the saturating short periods, the longest period and raw random words.
  task automatic random_sample();
    logic [PERIOD_W-1:0] period;
    logic [SET_W-1:0]    set_pt;
    int                  r;
    r = $urandom_range(99);
    if (r < 3) begin
      period = '0;
    end else if (r < 10) begin
      period = $urandom;
    end else if (r < 17) begin
      period = $urandom_range(25000, 1);
    end else if (r < 20) begin
      period = '1;
    end else begin
      period = $urandom_range(400000, 20000);
    end
    r = $urandom_range(99);
    if (r < 20) begin
      set_pt = SET_MARKS[4'($urandom_range(11))];
    end else if (r < 35) begin
      set_pt = 16'($urandom);
    end else begin
      set_pt = 16'($urandom_range(12000, 2000));
    end
    push_sample(period, set_pt);
  endtask

  // Lowers valid and waits for every predicted result to be taken, leaving the
  // block idle so that registers may be rewritten.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending_results == 0);
    @(posedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: moderate gains, zero and extreme periods, set points at the
    // field extremes and on both sides of each band edge.
    load_regs(16'h0100, 16'h0010, 16'hFF80, 16'hFFFF, 8'd200, 8'd16);
    push_sample(32'd0, 16'd0);
    push_sample(32'd0, 16'hFFFF);
    push_sample(32'hFFFF_FFFF, 16'hFFFF);
    push_sample(32'd1, 16'd0);
    for (int n = 1; n < 11; n++) begin
      push_sample(32'd100000, SET_MARKS[n]);
    end
    drain();

    // Stray writes to unused indexes, then signed gain extremes, a zero term
    // limit and crossed PWM bounds, where the lower bound must win.
    put_reg(CFG_SPARE_LO, 16'hFFFF);
    put_reg(CFG_SPARE_HI, 16'h5A5A);
    load_regs(16'h8000, 16'h7FFF, 16'h8000, 16'h0000, 8'd10, 8'd250);
    push_sample(32'hFFFF_FFFF, 16'hFFFF);
    push_sample(32'd1, 16'd0);
    push_sample(32'd0, 16'd7000);
    push_sample(32'd250000, 16'd3000);
    push_sample(32'h8000_0000, 16'd1);
    drain();

    load_regs(16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF, 8'd255, 8'd0);
    push_sample(32'hFFFF_FFFF, 16'hFFFF);
    push_sample(32'd21000, 16'd6500);
    push_sample(32'd1, 16'd1201);
    drain();

    // Random: the sender idles less than the receiver ...
    repeat (2) begin
      shuffle_regs();
      repeat (30) random_sample();
      drain();
    end

    // ... then the other way round ...
    send_idle_pct = 65;
    recv_idle_pct = 30;
    repeat (2) begin
      shuffle_regs();
      repeat (30) random_sample();
      drain();
    end

    // ... then neither side holds off.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    shuffle_regs();
    repeat (20) random_sample();
    drain();

    // A long run of large positive errors against the most negative integral
    // gain walks the integral down until it saturates at the signed floor.
    load_regs(16'($urandom_range(64)), 16'h8000, 16'($urandom_range(64)), 16'hFFFF,
              8'd255, 8'd0);
    repeat (280) begin
      push_sample($urandom_range(32'hFFFF_FFFF, 32'h1000_0000),
                  16'($urandom_range(16'hFFFF, 16'd65300)));
    end
    drain();

    // Allow a full update time for any stray beat to show up.
    repeat (64) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/pfpr_pkg.sv
rtl/pfpr_div.sv
rtl/pfpr_mul.sv
rtl/pump_flow_pid_regulator_unit.sv
rtl/pfpr_checker.sv
test/pump_flow_pid_regulator_checker.sv
test/pump_flow_pid_regulator_unit_tb.sv
